[rtl/core/rgbwf_pkg.sv]
`default_nettype none
package rgbwf_pkg;

  localparam int ChannelBitsDef = 8;
  localparam int ColW           = 8;
  localparam int SpanW          = 16;
  localparam int GainW          = 9;
  localparam int IntervalW      = 8;
  localparam int ReqW           = 3;
  localparam int DutyW          = 8;
  localparam int CfgIdxW        = 8;
  localparam int CfgDataW       = 9;
  localparam int InDataW        = 3 * ColW + SpanW;
  localparam int OutDataW       = 4 * DutyW;
  localparam int OutUserW       = 2;

  localparam logic [IntervalW-1:0] StepIntervalRst = 8'd10;
  localparam logic [GainW-1:0]     GainRst         = 9'd256;

  typedef enum logic [ReqW-1:0] {
    ReqTick     = 3'd0,
    ReqSet      = 3'd1,
    ReqFade     = 3'd2,
    ReqFlashOn  = 3'd3,
    ReqFlashOff = 3'd4
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStepInterval = 8'd0,
    CfgGain         = 8'd1
  } cfg_idx_e;

endpackage
`default_nettype wire

[rtl/core/rgbw_led_fade_flash_controller_core.sv]
// tick, set, flash and unknown commands pass through the load, scale and output states
// after the input transfer; a fade command first runs four serial divisions (the step
// count, then one per channel) in the bit-serial divider before taking the same path
// one item at a time: the next item is taken once this one's result sits in the output register,
// so a stalled output also holds off the next input transfer
// the results come from the bit-serial divider and the shift-add brightness scaler
// rst_ni is asynchronous, active low; all state returns to its reset values at once
`default_nettype none
module rgbw_led_fade_flash_controller_core import rgbwf_pkg::*; #(
  parameter int CHANNEL_BITS = ChannelBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output      logic                 s_axis_tready_o,
  // red_value, green_value, blue_value, span_ms
  input  wire logic [InDataW-1:0]   s_axis_tdata_i,
  // req_type
  input  wire logic [ReqW-1:0]      s_axis_tuser_i,
  output      logic                 m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // duty_red, duty_green, duty_blue, duty_white
  output      logic [OutDataW-1:0]  m_axis_tdata_o,
  // is_fading, flash_lit
  output      logic [OutUserW-1:0]  m_axis_tuser_o,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int CB = CHANNEL_BITS;
  localparam int LW = CB + 8;
  localparam int DW = (LW > SpanW) ? LW : SpanW;
  localparam int XW = (CB > ColW) ? CB : ColW;
  localparam logic [CB-1:0] ChanMax  = '1;
  localparam logic [LW-1:0] LevelMax = {ChanMax, 8'h00};
  localparam logic [1:0]    LastCh   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEPS,
    ST_QGO,
    ST_QUOT,
    ST_LOAD,
    ST_SCALE,
    ST_OUT
  } state_e;

  state_e                 state_q;
  logic [2:0][LW-1:0]     level_q;
  logic [2:0][LW:0]       step_q;
  logic [2:0][CB-1:0]     target_q;
  logic [SpanW-1:0]       steps_left_q;
  logic                   fade_active_q;
  logic [SpanW-1:0]       ms_q;
  logic                   flash_en_q;
  logic                   flash_ph_q;
  logic [2:0][CB-1:0]     flash_col_q;
  logic [SpanW-1:0]       flash_period_q;
  logic [IntervalW-1:0]   si_q;
  logic [GainW-1:0]       gain_q;
  logic [2:0][CB-1:0]     col_q;
  logic [SpanW-1:0]       steps_q;
  logic [1:0]             ch_q;
  logic                   m_valid_q;
  logic [OutDataW-1:0]    m_data_q;
  logic [OutUserW-1:0]    m_user_q;

  logic                   s_accept;
  req_e                   req;
  logic [2:0][ColW-1:0]   col_raw;
  logic [2:0][CB-1:0]     col_in;
  logic [SpanW-1:0]       span_in;
  logic [IntervalW-1:0]   iv_eff;
  logic [SpanW-1:0]       span_eff;

  logic [2:0][LW+1:0]     sum_v;
  logic [2:0][LW-1:0]     lvl_step;
  logic [2:0][LW-1:0]     tk_level;
  logic [SpanW-1:0]       tk_sl;
  logic                   tk_fa;
  logic                   tk_ph;
  logic [SpanW-1:0]       tk_ms;

  logic [LW:0]            diff;
  logic                   diff_neg;
  logic [LW:0]            diff_abs;
  logic [LW:0]            step_new;

  logic                   div_start;
  logic [DW-1:0]          div_dividend;
  logic [SpanW-1:0]       div_divisor;
  logic                   div_done;
  logic [DW-1:0]          div_quo;

  logic [LW-1:0]          w01;
  logic [LW-1:0]          wmin;
  logic                   scale_done;
  logic [3:0][DutyW-1:0]  duty;

  function automatic logic [CB-1:0] sat_col(logic [ColW-1:0] c);
    logic [XW-1:0] cx;
    cx = XW'(c);
    return (cx > XW'(ChanMax)) ? ChanMax : cx[CB-1:0];
  endfunction

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign req             = req_e'(s_axis_tuser_i);
  assign col_raw[0]      = s_axis_tdata_i[ColW-1:0];
  assign col_raw[1]      = s_axis_tdata_i[2*ColW-1:ColW];
  assign col_raw[2]      = s_axis_tdata_i[3*ColW-1:2*ColW];
  assign span_in         = s_axis_tdata_i[InDataW-1:3*ColW];
  assign cfg_ready_o     = 1'b1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      col_in[i] = sat_col(col_raw[i]);
    end
  end

  assign iv_eff   = (si_q == '0) ? IntervalW'(1) : si_q;
  assign span_eff = (span_in < SpanW'(iv_eff)) ? SpanW'(iv_eff) : span_in;

  // one fade step per channel, clamped to the level range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_v[i] = {2'b00, level_q[i]} - {step_q[i][LW], step_q[i]};
      if (sum_v[i][LW+1]) begin
        lvl_step[i] = '0;
      end else if (sum_v[i][LW:0] > {1'b0, LevelMax}) begin
        lvl_step[i] = LevelMax;
      end else begin
        lvl_step[i] = sum_v[i][LW-1:0];
      end
    end
  end

  always_comb begin
    tk_level = level_q;
    tk_sl    = steps_left_q;
    tk_fa    = fade_active_q;
    tk_ph    = flash_ph_q;
    tk_ms    = (ms_q != '1) ? (ms_q + 1'b1) : ms_q;
    if (fade_active_q && (tk_ms >= SpanW'(iv_eff))) begin
      if (steps_left_q != '0) begin
        tk_level = lvl_step;
        tk_sl    = steps_left_q - 1'b1;
        if (tk_sl == '0) begin
          for (int i = 0; i < 3; i++) begin
            tk_level[i] = {target_q[i], 8'h00};
          end
        end
      end else begin
        tk_fa = 1'b0;
      end
      tk_ms = '0;
    end
    if (flash_en_q && (tk_ms >= flash_period_q)) begin
      tk_ph = !flash_ph_q;
      for (int i = 0; i < 3; i++) begin
        tk_level[i] = tk_ph ? {flash_col_q[i], 8'h00} : '0;
      end
      tk_ms = '0;
    end
  end

  // signed per-step amount for the channel under division
  always_comb begin
    diff     = {1'b0, level_q[ch_q]} - {1'b0, col_q[ch_q], 8'h00};
    diff_neg = diff[LW];
    diff_abs = diff_neg ? (~diff + 1'b1) : diff;
    step_new = diff_neg ? (~{1'b0, div_quo[LW-1:0]} + 1'b1) : {1'b0, div_quo[LW-1:0]};
  end

  always_comb begin
    div_start    = (s_accept && (req == ReqFade)) || (state_q == ST_QGO);
    div_dividend = (state_q == ST_QGO) ? DW'(diff_abs[LW-1:0]) : DW'(span_eff);
    div_divisor  = (state_q == ST_QGO) ? steps_q : SpanW'(iv_eff);
  end

  rgbwf_div #(
    .DW(DW)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign w01  = (level_q[1] < level_q[0]) ? level_q[1] : level_q[0];
  assign wmin = (level_q[2] < w01) ? level_q[2] : w01;

  rgbwf_scale #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_scale (
    .clk_i,
    .rst_ni,
    .start_i (state_q == ST_LOAD),
    .level_i ({wmin, level_q[2], level_q[1], level_q[0]}),
    .gain_i  (gain_q),
    .done_o  (scale_done),
    .duty_o  (duty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      level_q        <= '0;
      step_q         <= '0;
      target_q       <= '0;
      steps_left_q   <= '0;
      fade_active_q  <= 1'b0;
      ms_q           <= '0;
      flash_en_q     <= 1'b0;
      flash_ph_q     <= 1'b0;
      flash_col_q    <= '0;
      flash_period_q <= '0;
      si_q           <= StepIntervalRst;
      gain_q         <= GainRst;
      col_q          <= '0;
      steps_q        <= '0;
      ch_q           <= '0;
      m_valid_q      <= 1'b0;
      m_data_q       <= '0;
      m_user_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgStepInterval: si_q <= cfg_data_i[IntervalW-1:0];
          CfgGain:         gain_q <= cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end
      if (m_valid_q && m_axis_tready_i && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            col_q   <= col_in;
            state_q <= ST_LOAD;
            case (req)
              ReqTick: begin
                level_q       <= tk_level;
                steps_left_q  <= tk_sl;
                fade_active_q <= tk_fa;
                ms_q          <= tk_ms;
                flash_ph_q    <= tk_ph;
              end
              ReqSet: begin
                fade_active_q <= 1'b0;
                flash_en_q    <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                  level_q[i] <= {col_in[i], 8'h00};
                end
              end
              ReqFade: begin
                state_q <= ST_STEPS;
              end
              ReqFlashOn: begin
                flash_period_q <= span_in;
                flash_en_q     <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                  flash_col_q[i] <= level_q[i][LW-1:8];
                end
              end
              ReqFlashOff: begin
                flash_en_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_STEPS: begin
          if (div_done) begin
            steps_q <= div_quo[SpanW-1:0];
            ch_q    <= '0;
            state_q <= ST_QGO;
          end
        end
        ST_QGO: begin
          state_q <= ST_QUOT;
        end
        ST_QUOT: begin
          if (div_done) begin
            step_q[ch_q]   <= step_new;
            target_q[ch_q] <= col_q[ch_q];
            if (ch_q == LastCh) begin
              steps_left_q  <= steps_q;
              fade_active_q <= 1'b1;
              state_q       <= ST_LOAD;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= ST_QGO;
            end
          end
        end
        ST_LOAD: begin
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          if (scale_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= duty;
            m_user_q  <= {flash_en_q & flash_ph_q, fade_active_q};
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule
`default_nettype wire

[rtl/core/rgbwf_div.sv]
`default_nettype none
module rgbwf_div import rgbwf_pkg::*; #(
  parameter int DW = ChannelBitsDef + 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [DW-1:0]       dividend_i,
  input  wire logic [SpanW-1:0]    divisor_i,
  output      logic                done_o,
  output      logic [DW-1:0]       quotient_o
);

  localparam int CntW = $clog2(DW);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [DW-1:0]     quo_q;
  logic [SpanW:0]    rem_q;
  logic [SpanW-1:0]  den_q;
  logic [SpanW:0]    rem_sh;
  logic              fits;
  logic [SpanW:0]    rem_nx;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem_q[SpanW-1:0], quo_q[DW-1]};
    fits   = rem_sh >= {1'b0, den_q};
    rem_nx = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= dividend_i;
        rem_q  <= '0;
        den_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= rem_nx;
        quo_q <= {quo_q[DW-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

[rtl/core/rgbwf_scale.sv]
`default_nettype none
module rgbwf_scale import rgbwf_pkg::*; #(
  parameter int CHANNEL_BITS = ChannelBitsDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  input  wire logic [3:0][CHANNEL_BITS+7:0]           level_i,
  input  wire logic [GainW-1:0]                       gain_i,
  output      logic                                   done_o,
  output      logic [3:0][DutyW-1:0]                  duty_o
);

  localparam int LW   = CHANNEL_BITS + 8;
  localparam int AW   = LW + GainW;
  localparam int CntW = $clog2(GainW);
  localparam logic [CHANNEL_BITS-1:0] ChanMax = '1;

  logic                  busy_q;
  logic                  done_q;
  logic [CntW-1:0]       cnt_q;
  logic [GainW-1:0]      gain_q;
  logic [3:0][LW-1:0]    val_q;
  logic [3:0][AW-1:0]    acc_q;
  logic [3:0][CHANNEL_BITS:0]   hi;
  logic [3:0][CHANNEL_BITS-1:0] dsat;

  // shift-add over the gain bits, msb first, four lanes side by side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      gain_q <= '0;
      val_q  <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        gain_q <= gain_i;
        val_q  <= level_i;
        acc_q  <= '0;
      end else if (busy_q) begin
        for (int i = 0; i < 4; i++) begin
          acc_q[i] <= {acc_q[i][AW-2:0], 1'b0}
                    + (gain_q[GainW-1] ? AW'(val_q[i]) : AW'(0));
        end
        gain_q <= {gain_q[GainW-2:0], 1'b0};
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == CntW'(GainW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hi[i]     = acc_q[i][AW-1:16];
      dsat[i]   = (hi[i] > {1'b0, ChanMax}) ? ChanMax : hi[i][CHANNEL_BITS-1:0];
      duty_o[i] = DutyW'(dsat[i]);
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire
